// ===== design/fwrg_pkg.sv =====
// ----------------------------------------------------------------------------
// fwrg_pkg
// Shared widths, register indexes and divider status type for the factoring
// work range generator.
// ----------------------------------------------------------------------------
package fwrg_pkg;

  localparam int DATA_W = 32;            // index and size width
  localparam int WORK_W = 9;             // worker count width
  localparam int DIV_W  = DATA_W + 1;    // dividend width, room for len + w - 1
  localparam int DVS_W  = WORK_W + 1;    // divisor width, room for w + 1

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBLEM_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 1'd1;

  localparam int SPLIT_FACTOR_DEF = 500;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/fwrg_divider.sv =====
// ----------------------------------------------------------------------------
// fwrg_divider
// Bit-serial restoring divider: one quotient bit per cycle, dividend shifted
// out of the top of the quotient register as quotient bits shift in.
// ----------------------------------------------------------------------------
module fwrg_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fwrg_pkg::DIV_W-1:0] dividend,
  input  logic [fwrg_pkg::DVS_W-1:0] divisor,
  output fwrg_pkg::div_stat_t        stat,
  output logic [fwrg_pkg::DIV_W-1:0] quotient
);
  import fwrg_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== design/factoring_work_range_generator_core.sv =====
// ----------------------------------------------------------------------------
// factoring_work_range_generator_core
// Hands out [start, end) work ranges over 0..problem_size by factoring
// scheduling; chunk and piece sizes come from a shared bit-serial divider.
// ----------------------------------------------------------------------------
// channel   dir  signals                      contents
// in_       in   tvalid tready tdata[7:0]     request
// out_      out  tvalid tready tdata[63:0]    range_start, range_end
//                tuser[0]                     has_task
// cfg_      in   wr_en index[0] wdata[31:0]   problem_size, worker_count
//
// an item with request clear is taken and gives no result.
// a piece of the current chunk, the single-worker range or a no-task answer
// passes S_START and then S_EMIT, where its result is registered; the first
// item of a span with several workers passes S_START once more. cutting a new
// chunk adds two divisions (S_DIV1, S_DIV2), the last chunk below the
// threshold one (S_DIV2); the divider retires one quotient bit per cycle.
// in_tready is high only while no item is in work; a result waiting on
// out_tready does not block the next item until its own result is ready.
// rst_n is synchronous; any configuration write restarts the span.
// ----------------------------------------------------------------------------
module factoring_work_range_generator_core #(
  parameter int SPLIT_FACTOR = fwrg_pkg::SPLIT_FACTOR_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [0] request
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // [31:0] range_start, [63:32] range_end
  output logic [0:0]                     out_tuser,  // [0] has_task
  input  logic                           cfg_wr_en,
  input  logic [fwrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fwrg_pkg::DATA_W-1:0]    cfg_wdata
);
  import fwrg_pkg::*;

  localparam int SPLIT_W = $clog2(SPLIT_FACTOR + 1);
  localparam int THR_W   = SPLIT_W + WORK_W;
  localparam int CMP_W   = (THR_W > DATA_W) ? THR_W : DATA_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_DIV1  = 5'b00100,
    S_DIV2  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  state_t              state_r, state_nxt;
  phase_t              phase_r;
  logic [DATA_W-1:0]   problem_r;
  logic [WORK_W-1:0]   worker_r;
  logic [DATA_W-1:0]   base_r, remain_r, pstart_r, limit_r, psize_r, len_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_start_r, out_end_r;
  logic                out_has_r;

  logic [WORK_W-1:0]   eff_w;
  logic [THR_W-1:0]    thr;
  logic                rem_lt_thr;
  logic                slot_free;
  logic                in_acc;
  logic [DATA_W-1:0]   len_sel;
  logic [DATA_W-1:0]   limit_new;
  logic [DATA_W:0]     piece_end;
  logic [DATA_W-1:0]   piece_clip;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  div_stat_t           div_stat;
  logic [DIV_W-1:0]    div_quot;

  fwrg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  assign eff_w      = (worker_r == '0) ? WORK_W'(1) : worker_r;
  assign thr        = THR_W'(SPLIT_FACTOR) * THR_W'(eff_w);
  assign rem_lt_thr = CMP_W'(remain_r) < CMP_W'(thr);
  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;

  // a zero quotient can only happen with a split factor below two; the remainder is used then
  assign len_sel   = (state_r == S_DIV1) ?
                     ((div_quot[DATA_W-1:0] == '0) ? remain_r : div_quot[DATA_W-1:0]) :
                     remain_r;
  assign limit_new = base_r + len_r;

  assign piece_end  = {1'b0, pstart_r} + {1'b0, psize_r};
  assign piece_clip = (piece_end > {1'b0, limit_r} || psize_r == '0) ?
                      limit_r : piece_end[DATA_W-1:0];

  // divider hookup: chunk cut divides by w + 1, piece size divides by w
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b0, remain_r};
    div_divisor  = DVS_W'(eff_w) + 1'b1;
    if (state_r == S_START && phase_r == PH_RUN && pstart_r >= limit_r &&
        remain_r != '0) begin
      div_start = 1'b1;
      if (rem_lt_thr) begin
        div_dividend = {1'b0, remain_r} + DIV_W'(eff_w) - 1'b1;
        div_divisor  = DVS_W'(eff_w);
      end
    end else if (state_r == S_DIV1 && div_stat.done) begin
      div_start    = 1'b1;
      div_dividend = {1'b0, len_sel} + DIV_W'(eff_w) - 1'b1;
      div_divisor  = DVS_W'(eff_w);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_tdata[0]) state_nxt = S_START;
      S_START: begin
        case (phase_r)
          PH_IDLE: if (eff_w == WORK_W'(1)) state_nxt = S_EMIT;
          PH_RUN: begin
            if (pstart_r >= limit_r && remain_r != '0) begin
              state_nxt = rem_lt_thr ? S_DIV2 : S_DIV1;
            end else begin
              state_nxt = S_EMIT;
            end
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      S_DIV1:  if (div_stat.done) state_nxt = S_DIV2;
      S_DIV2:  if (div_stat.done) state_nxt = S_START;
      S_EMIT:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      problem_r   <= '0;
      worker_r    <= WORK_W'(1);
      base_r      <= '0;
      remain_r    <= '0;
      pstart_r    <= '0;
      limit_r     <= '0;
      psize_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_START: begin
          case (phase_r)
            PH_IDLE: begin
              if (eff_w != WORK_W'(1)) begin
                base_r   <= '0;
                remain_r <= problem_r;
                pstart_r <= '0;
                limit_r  <= '0;
                psize_r  <= '0;
                phase_r  <= PH_RUN;
              end
            end
            PH_RUN: begin
              if (pstart_r >= limit_r && remain_r == '0) phase_r <= PH_DONE;
            end
            default: ;
          endcase
        end
        S_DIV2: begin
          if (div_stat.done) begin
            pstart_r <= base_r;
            limit_r  <= limit_new;
            base_r   <= limit_new;
            psize_r  <= div_quot[DATA_W-1:0];
            remain_r <= remain_r - len_r;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            case (phase_r)
              PH_IDLE: phase_r  <= PH_DONE;
              PH_RUN:  pstart_r <= piece_clip;
              default: ;
            endcase
          end
        end
        default: ;
      endcase

      // any write restarts the span
      if (cfg_wr_en) begin
        phase_r <= PH_IDLE;
        if (cfg_index == CFG_PROBLEM_SIZE) begin
          problem_r <= cfg_wdata;
        end else if (cfg_index == CFG_WORKER_COUNT) begin
          worker_r <= cfg_wdata[WORK_W-1:0];
        end
      end
    end
  end

  // chunk length latched at each divider start; the piece-size start sets the value used
  always_ff @(posedge clk) begin
    if (div_start) len_r <= len_sel;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && slot_free) begin
      case (phase_r)
        PH_IDLE: begin
          out_start_r <= '0;
          out_end_r   <= problem_r;
          out_has_r   <= 1'b1;
        end
        PH_RUN: begin
          out_start_r <= pstart_r;
          out_end_r   <= piece_clip;
          out_has_r   <= 1'b1;
        end
        default: begin
          out_start_r <= '0;
          out_end_r   <= '0;
          out_has_r   <= 1'b0;
        end
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_end_r, out_start_r};
  assign out_tuser[0] = out_has_r;

  // assertions
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_piece_in_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RUN) |-> (pstart_r <= limit_r))
    else $error("piece start beyond chunk limit");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_has_r) |-> (out_start_r <= out_end_r))
    else $error("range start above range end");

  a_no_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_r) |-> (out_start_r == '0 && out_end_r == '0))
    else $error("no-task item carries a range");

endmodule
